// ===== sv/bb3_pkg.sv =====
// Shared types, constants and the reciprocal table for the 3x3 box blur.
package bb3_pkg;

  // Line store depth and the widths that follow from it
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned CFG_WW    = 11;  // image_width register
  localparam int unsigned CFG_HW    = 16;  // image_height register
  localparam int unsigned EW_W      = (COL_W + 1 > CFG_WW) ? COL_W + 1 : CFG_WW;
  localparam int unsigned ROW_W     = CFG_HW + 1;  // row runs one past height in the tail
  localparam int unsigned PIX_W     = 24;
  localparam int unsigned SUM_W     = 12;  // 9 * 255
  localparam int unsigned NUM_W     = SUM_W + 1;
  localparam int unsigned RCP_W     = 18;
  localparam int unsigned RCP_SHIFT = 18;
  localparam int unsigned PROD_W    = NUM_W + RCP_W;

  // Configuration register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SUM,
    S_MUL
  } state_t;

  typedef struct packed {
    logic accept;  // input beat taken this edge
    logic shift;   // write line stores, shift window
    logic sum;     // register sums and divisor reciprocal
    logic load;    // load output register
  } cmd_t;

  typedef struct packed {
    logic skip;      // drain beat while frame pixels still due
    logic emit;      // current item produces a result
    logic out_free;  // output register can take a result
  } sts_t;

  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
    logic last;
  } geo_t;

  // ceil(2^18 / (2*cnt)); exact floor division of the 13-bit numerator
  function automatic logic [RCP_W-1:0] recip(input logic [3:0] cnt);
    logic [RCP_W-1:0] m;
    case (cnt)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/bb3_ctrl.sv =====
// Sequencer for the 3x3 box blur: accept, shift, sum, divide/load.
module bb3_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bb3_pkg::sts_t sts,
  output bb3_pkg::cmd_t cmd
);

  bb3_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bb3_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bb3_pkg::S_IDLE: begin
        if (in_valid && !sts.skip) state_nxt = bb3_pkg::S_SHIFT;
      end
      bb3_pkg::S_SHIFT: begin
        state_nxt = sts.emit ? bb3_pkg::S_SUM : bb3_pkg::S_IDLE;
      end
      bb3_pkg::S_SUM: begin
        state_nxt = bb3_pkg::S_MUL;
      end
      bb3_pkg::S_MUL: begin
        if (sts.out_free) state_nxt = bb3_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bb3_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd        = '0;
    case (state_r)
      bb3_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      bb3_pkg::S_SHIFT: begin
        cmd.shift = 1'b1;
      end
      bb3_pkg::S_SUM: begin
        cmd.sum = 1'b1;
      end
      bb3_pkg::S_MUL: begin
        cmd.load = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/bb3_dp.sv =====
// Datapath: geometry counters, line stores, 3x3 window, averaging and output register.
module bb3_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bb3_pkg::cmd_t               cmd,
  output bb3_pkg::sts_t               sts,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bb3_pkg::CFG_HW-1:0]  cfg_wdata,
  input  logic                        in_action,
  input  logic [7:0]                  in_pixel_blue,
  input  logic [7:0]                  in_pixel_green,
  input  logic [7:0]                  in_pixel_red,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [7:0]                  out_blur_blue,
  output logic [7:0]                  out_blur_green,
  output logic [7:0]                  out_blur_red,
  output logic                        out_frame_end
);

  // config and position
  logic [bb3_pkg::CFG_WW-1:0] width_r;
  logic [bb3_pkg::CFG_HW-1:0] height_r;
  logic [bb3_pkg::COL_W-1:0]  col_r;
  logic [bb3_pkg::ROW_W-1:0]  row_r;

  // per-item state
  logic                        emit_r;
  bb3_pkg::geo_t               geo_r;
  logic [bb3_pkg::COL_W-1:0]   addr_r;
  logic [bb3_pkg::PIX_W-1:0]   newpix_r;
  logic [bb3_pkg::PIX_W-1:0]   top_r;
  logic [bb3_pkg::PIX_W-1:0]   mid_r;

  // line stores
  logic [bb3_pkg::PIX_W-1:0]   prev_line_mem   [bb3_pkg::MAX_WIDTH];
  logic [bb3_pkg::PIX_W-1:0]   second_line_mem [bb3_pkg::MAX_WIDTH];

  // window [column: left, mid, right][row: top, mid, bottom]
  logic [bb3_pkg::PIX_W-1:0]   win_r [3][3];

  // arithmetic
  logic [bb3_pkg::NUM_W-1:0]   num_r [3];
  logic [bb3_pkg::RCP_W-1:0]   recip_r;
  logic                        out_valid_r;
  logic [7:0]                  out_blue_r;
  logic [7:0]                  out_green_r;
  logic [7:0]                  out_red_r;
  logic                        out_last_r;

  // geometry combinational
  logic [bb3_pkg::EW_W-1:0]    w_eff;
  logic [bb3_pkg::CFG_HW-1:0]  h_eff;
  logic                        in_frame;
  logic                        col_nz;
  logic signed [bb3_pkg::ROW_W:0] cr;
  logic                        cr_ok;
  logic [bb3_pkg::EW_W-1:0]    cc;
  logic [bb3_pkg::EW_W-1:0]    col_p1;
  bb3_pkg::geo_t               geo_c;
  logic                        take;

  logic [bb3_pkg::SUM_W-1:0]   sum_c [3];
  logic [1:0]                  nx;
  logic [1:0]                  ny;
  logic [3:0]                  cnt_c;
  logic [2:0]                  col_ok;
  logic [2:0]                  row_ok;
  logic [bb3_pkg::PROD_W-1:0]  prod_c [3];

  always_comb begin
    if (width_r == '0) begin
      w_eff = bb3_pkg::EW_W'(1);
    end else if (bb3_pkg::EW_W'(width_r) > bb3_pkg::EW_W'(bb3_pkg::MAX_WIDTH)) begin
      w_eff = bb3_pkg::EW_W'(bb3_pkg::MAX_WIDTH);
    end else begin
      w_eff = bb3_pkg::EW_W'(width_r);
    end
    h_eff = (height_r == '0) ? bb3_pkg::CFG_HW'(1) : height_r;
  end

  assign in_frame = row_r < {1'b0, h_eff};
  assign col_nz   = col_r != '0;
  assign take     = cmd.accept && !sts.skip;

  // window centre: one row and one column behind the input position
  always_comb begin
    cr     = $signed({1'b0, row_r}) - (col_nz ? 18'sd1 : 18'sd2);
    cr_ok  = !cr[bb3_pkg::ROW_W] && (cr[bb3_pkg::ROW_W-1:0] < {1'b0, h_eff});
    cc     = col_nz ? (bb3_pkg::EW_W'(col_r) - bb3_pkg::EW_W'(1))
                    : (w_eff - bb3_pkg::EW_W'(1));
    col_p1 = bb3_pkg::EW_W'(col_r) + bb3_pkg::EW_W'(1);
    geo_c.left  = cc != '0;
    geo_c.right = cc != (w_eff - bb3_pkg::EW_W'(1));
    geo_c.up    = cr[bb3_pkg::ROW_W-1:0] != '0;
    geo_c.down  = cr[bb3_pkg::ROW_W-1:0] != ({1'b0, h_eff} - bb3_pkg::ROW_W'(1));
    geo_c.last  = cr_ok && !geo_c.right && !geo_c.down;
  end

  always_comb begin
    sts.skip     = in_action && in_frame;
    sts.emit     = emit_r;
    sts.out_free = !out_valid_r || !out_stall;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= bb3_pkg::CFG_WW'(1024);
      height_r    <= bb3_pkg::CFG_HW'(768);
      col_r       <= '0;
      row_r       <= '0;
      emit_r      <= 1'b0;
      geo_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bb3_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_wdata[bb3_pkg::CFG_WW-1:0];
          bb3_pkg::CFG_IDX_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (take) begin
        emit_r <= cr_ok;
        geo_r  <= geo_c;
        if (geo_c.last) begin
          col_r <= '0;
          row_r <= '0;
        end else if (col_p1 >= w_eff) begin
          col_r <= '0;
          row_r <= row_r + bb3_pkg::ROW_W'(1);
        end else begin
          col_r <= col_p1[bb3_pkg::COL_W-1:0];
        end
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line stores: read on accept, write back on shift
  always_ff @(posedge clk) begin
    if (take) begin
      top_r    <= second_line_mem[col_r];
      mid_r    <= prev_line_mem[col_r];
      addr_r   <= col_r;
      newpix_r <= in_frame ? {in_pixel_red, in_pixel_green, in_pixel_blue} : '0;
    end
    if (cmd.shift) begin
      second_line_mem[addr_r] <= mid_r;
      prev_line_mem[addr_r]   <= newpix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int j = 0; j < 3; j++) begin
        win_r[0][j] <= win_r[1][j];
        win_r[1][j] <= win_r[2][j];
      end
      win_r[2][0] <= top_r;
      win_r[2][1] <= mid_r;
      win_r[2][2] <= newpix_r;
    end
  end

  // masked window sums and neighbour count
  always_comb begin
    col_ok = {geo_r.right, 1'b1, geo_r.left};
    row_ok = {geo_r.down, 1'b1, geo_r.up};
    nx     = 2'd1 + {1'b0, geo_r.left} + {1'b0, geo_r.right};
    ny     = 2'd1 + {1'b0, geo_r.up} + {1'b0, geo_r.down};
    cnt_c  = {2'b00, nx} * {2'b00, ny};
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (col_ok[i] && row_ok[j]) begin
            sum_c[ch] = sum_c[ch] + bb3_pkg::SUM_W'(win_r[i][j][8*ch +: 8]);
          end
        end
      end
    end
  end

  // (2*sum + cnt) * ceil(2^18 / 2cnt) >> 18 == round-half-up average
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      for (int ch = 0; ch < 3; ch++) begin
        num_r[ch] <= {sum_c[ch], 1'b0} + bb3_pkg::NUM_W'(cnt_c);
      end
      recip_r <= bb3_pkg::recip(cnt_c);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod_c[ch] = bb3_pkg::PROD_W'(num_r[ch]) * bb3_pkg::PROD_W'(recip_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_blue_r  <= prod_c[0][bb3_pkg::RCP_SHIFT +: 8];
      out_green_r <= prod_c[1][bb3_pkg::RCP_SHIFT +: 8];
      out_red_r   <= prod_c[2][bb3_pkg::RCP_SHIFT +: 8];
      out_last_r  <= geo_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blur_blue  = out_blue_r;
  assign out_blur_green = out_green_r;
  assign out_blur_red   = out_red_r;
  assign out_frame_end  = out_last_r;

endmodule

// ===== sv/box_blur_3x3_edge_aware.sv =====
// Top level of the streaming 3x3 edge-aware box blur.
//
// Input channel: in_valid/in_stall with in_action and an RGB pixel. Pixels of
// a frame arrive in raster order (in_action = 0); once all width*height
// pixels are in, width+1 drain beats (in_action = 1) flush the tail. A drain
// beat that arrives while frame pixels are still due is taken and dropped.
// Output channel: out_valid/out_stall with the rounded average of each
// channel over the in-frame 3x3 neighbourhood; out_frame_end marks the last
// result of a frame, after which the next beat starts a new frame.
// The result for raster pixel k leaves on the beat for input item k+width+1.
// Steps: an item producing a result goes through accept, line store write
// and window shift, masked sum, and reciprocal multiply into the output
// register; an item with no result ends after the shift, a dropped drain
// beat after accept. One item is in flight at a time, so these steps set
// the rate. The output register holds a finished beat while the receiver
// stalls and the next item is accepted meanwhile; only the final load waits.
// Config: cfg_we writes image_width (index 0) or image_height (index 1)
// and restarts the frame; write only while idle. Reset restores 1024x768
// and frame position zero; line store contents are not cleared.
module box_blur_3x3_edge_aware (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bb3_pkg::CFG_HW-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [7:0]                 in_pixel_blue,
  input  logic [7:0]                 in_pixel_green,
  input  logic [7:0]                 in_pixel_red,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_blur_blue,
  output logic [7:0]                 out_blur_green,
  output logic [7:0]                 out_blur_red,
  output logic                       out_frame_end
);

  bb3_pkg::cmd_t cmd;
  bb3_pkg::sts_t sts;

  // sequencer: one item in flight, stalls input outside idle
  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // line stores, window, geometry and averaging
  bb3_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_action      (in_action),
    .in_pixel_blue  (in_pixel_blue),
    .in_pixel_green (in_pixel_green),
    .in_pixel_red   (in_pixel_red),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_blur_blue  (out_blur_blue),
    .out_blur_green (out_blur_green),
    .out_blur_red   (out_blur_red),
    .out_frame_end  (out_frame_end)
  );

endmodule

// ===== verif/box_blur_3x3_edge_aware_test.sv =====
// Self-checking testbench for the streaming 3x3 edge-aware box blur.
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_test;

  // in_action codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Idle cycles before a register write: covers a no-result item still in flight
  localparam int SETTLE_CYCLES = 12;
  // Frame and tail beats to play in the random part
  localparam int ITEM_TARGET   = 1900;
  // Cap on printed mismatch lines; every mismatch is still counted
  localparam int PRINT_CAP     = 40;

  // One result beat as seen on the output channel
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } blur_px_t;

  // Blur predictor plus the queue of results still owed by the block.
  class blur_scoreboard;
    logic [bb3_pkg::PIX_W-1:0]  row_above     [bb3_pkg::MAX_WIDTH];
    logic [bb3_pkg::PIX_W-1:0]  row_two_above [bb3_pkg::MAX_WIDTH];
    logic [bb3_pkg::PIX_W-1:0]  win [3][3];  // [column: left..right][row: top..bottom]
    logic [bb3_pkg::CFG_WW-1:0] width_reg;
    logic [bb3_pkg::CFG_HW-1:0] height_reg;
    int                col;
    int                row;
    int                emitted;
    blur_px_t          due[$];
    int                mismatches;

    function new();
      width_reg  = 11'd1024;
      height_reg = 16'd768;
      foreach (row_above[i]) begin
        row_above[i]     = '0;
        row_two_above[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      col     = 0;
      row     = 0;
      emitted = 0;
    endfunction

    // Width saturates to 1..MAX_WIDTH, height 0 reads as 1
    function int eff_width();
      if (width_reg == '0) return 1;
      if (int'(width_reg) > bb3_pkg::MAX_WIDTH) return bb3_pkg::MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int eff_height();
      return (height_reg == '0) ? 1 : int'(height_reg);
    endfunction

    function void set_reg(logic idx, logic [bb3_pkg::CFG_HW-1:0] val);
      if (idx == bb3_pkg::CFG_IDX_WIDTH) width_reg = val[bb3_pkg::CFG_WW-1:0];
      else height_reg = val;
      restart();
    endfunction

    // Round half up: (2*sum + n) / (2*n)
    function logic [7:0] rounded_mean(int total, int cnt);
      int q;
      q = (2 * total + cnt) / (2 * cnt);
      return q[7:0];
    endfunction

    // Accepted input beat: advance the window, queue the result it releases
    function void note_input(logic act, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int w, h, cr, cc, x, y, cnt, sb, sg, sr, i, j;
      logic [bb3_pkg::PIX_W-1:0] px, top, mid, p;
      blur_px_t res;
      w = eff_width();
      h = eff_height();
      // drain while frame pixels are still due: dropped
      if (act == ACT_DRAIN && row < h) return;
      // past the last frame pixel every beat acts as a drain
      px  = (row < h) ? {r, g, b} : '0;
      top = row_two_above[col];
      mid = row_above[col];
      row_two_above[col] = mid;
      row_above[col]     = px;
      for (i = 0; i < 2; i++)
        for (j = 0; j < 3; j++)
          win[i][j] = win[i + 1][j];
      win[2][0] = top;
      win[2][1] = mid;
      win[2][2] = px;
      // window center trails the input by width+1
      if (col >= 1) begin
        cr = row - 1;
        cc = col - 1;
      end else begin
        cr = row - 2;
        cc = w - 1;
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (cr < 0 || cr >= h) return;
      sb  = 0;
      sg  = 0;
      sr  = 0;
      cnt = 0;
      for (i = 0; i < 3; i++) begin
        x = cc + i - 1;
        if (x >= 0 && x < w) begin
          for (j = 0; j < 3; j++) begin
            y = cr + j - 1;
            if (y >= 0 && y < h) begin
              p = win[i][j];
              sb += p[7:0];
              sg += p[15:8];
              sr += p[23:16];
              cnt++;
            end
          end
        end
      end
      res.blue      = rounded_mean(sb, cnt);
      res.green     = rounded_mean(sg, cnt);
      res.red       = rounded_mean(sr, cnt);
      res.frame_end = (emitted + 1 >= w * h);
      if (res.frame_end) restart();
      else emitted++;
      due.push_back(res);
    endfunction

    task report(string what, int got, int want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    // Accepted output beat: compare with the oldest owed result
    task check_result(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fe);
      blur_px_t want;
      if (due.size() == 0) begin
        report("unexpected result beat, blue", b, 0);
        return;
      end
      want = due.pop_front();
      if (b !== want.blue)       report("blur_blue", b, want.blue);
      if (g !== want.green)      report("blur_green", g, want.green);
      if (r !== want.red)        report("blur_red", r, want.red);
      if (fe !== want.frame_end) report("frame_end", fe, want.frame_end);
    endtask

    task flush_leftovers();
      if (due.size() != 0) report("results never delivered", due.size(), 0);
    endtask
  endclass

  // Clock, reset and all block inputs start known
  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       cfg_we         = 1'b0;
  logic                       cfg_index      = 1'b0;
  logic [bb3_pkg::CFG_HW-1:0] cfg_wdata      = '0;
  logic                       in_valid       = 1'b0;
  logic                       in_action      = 1'b0;
  logic [7:0]                 in_pixel_blue  = '0;
  logic [7:0]                 in_pixel_green = '0;
  logic [7:0]                 in_pixel_red   = '0;
  logic                       out_stall      = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [7:0]                 out_blur_blue;
  logic [7:0]                 out_blur_green;
  logic [7:0]                 out_blur_red;
  logic                       out_frame_end;

  blur_scoreboard board;

  // Idling controls, changed per phase by the stimulus
  bit src_gaps    = 1'b0;
  bit rx_gaps     = 1'b0;
  int hold_cycles = 0;   // one-shot long receiver hold-off
  int items_played = 0;

  always #5 clk = ~clk;

  box_blur_3x3_edge_aware dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_pixel_blue  (in_pixel_blue),
    .in_pixel_green (in_pixel_green),
    .in_pixel_red   (in_pixel_red),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blur_blue  (out_blur_blue),
    .out_blur_green (out_blur_green),
    .out_blur_red   (out_blur_red),
    .out_frame_end  (out_frame_end)
  );

  // Beat monitor. Samples at the edge before any NBA lands, so it sees what
  // the block saw. The result is checked before the new input is noted: the
  // input taken at this edge cannot have produced this result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_blur_blue, out_blur_green, out_blur_red, out_frame_end);
    if (rst_n && in_valid && !in_stall)
      board.note_input(in_action, in_pixel_blue, in_pixel_green, in_pixel_red);
  end

  // Receiver: random stall before each result, plus any long hold-off that
  // the stimulus requested. Stall time is counted here, in cycles.
  initial begin
    int stall_n;
    forever begin
      stall_n     = rx_gaps ? $urandom_range(0, 4) : 0;
      stall_n    += hold_cycles;
      hold_cycles = 0;
      if (stall_n > 0) begin
        out_stall <= 1'b1;
        repeat (stall_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Random channel value, leaning a little toward the rails
  function automatic logic [7:0] chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one beat after a random gap and hold it until taken. Returns in
  // the step of the accepting edge; the caller either offers the next beat
  // right away or drops valid before it waits.
  task automatic send_beat(logic act, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int gap;
    gap = src_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_pixel_blue  <= b;
    in_pixel_green <= g;
    in_pixel_red   <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every owed result has been taken
  task automatic wait_results_in();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [bb3_pkg::CFG_HW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Quiesce, then write both registers. Upper width bits are junk that the
  // block must mask off.
  task automatic configure(int unsigned w_raw, int unsigned h_raw);
    wait_results_in();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(bb3_pkg::CFG_IDX_WIDTH, {5'($urandom), 11'(w_raw)});
    write_reg(bb3_pkg::CFG_IDX_HEIGHT, 16'(h_raw));
  endtask

  // Frame pixels. Now and then a drain beat is slipped in (must be dropped)
  // or the sender pauses until the block has caught up.
  task automatic play_pixels(int n);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0)
        send_beat(ACT_DRAIN, chan(), chan(), chan());
      if ($urandom_range(0, 99) == 0)
        wait_results_in();
      send_beat(ACT_PIXEL, chan(), chan(), chan());
      items_played++;
    end
  endtask

  // Tail beats: mostly drains, sometimes pixels whose data must be discarded
  task automatic play_tail(int n);
    repeat (n) begin
      send_beat(($urandom_range(0, 4) == 0) ? ACT_PIXEL : ACT_DRAIN,
                chan(), chan(), chan());
      items_played++;
    end
  endtask

  initial begin
    int phase, pick, w, h, frames, n;

    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed ----
    // Zero in both registers acts as a 1x1 frame. The leading drain is
    // dropped, the pixel beat after the frame is a drain with its data lost.
    configure(0, 0);
    send_beat(ACT_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    send_beat(ACT_PIXEL, 8'hFF, 8'h00, 8'hFF);
    send_beat(ACT_PIXEL, 8'h12, 8'h34, 8'h56);
    send_beat(ACT_DRAIN, 8'h00, 8'h00, 8'h00);

    // One column, three rows: vertical neighbors only
    configure(1, 3);
    send_beat(ACT_PIXEL, 8'h00, 8'hFF, 8'h00);
    send_beat(ACT_PIXEL, 8'hFF, 8'h00, 8'hFF);
    send_beat(ACT_PIXEL, 8'h01, 8'h01, 8'h00);
    send_beat(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_PIXEL, 8'hAA, 8'h55, 8'hAA);

    // 3x2: every pixel is a corner or an edge. Blue of the left corner sums
    // to 2 over 4 neighbors, so half rounds up to 1.
    configure(3, 2);
    send_beat(ACT_PIXEL, 8'h01, 8'hFF, 8'h00);
    send_beat(ACT_PIXEL, 8'h01, 8'hFF, 8'hFF);
    send_beat(ACT_PIXEL, 8'h00, 8'hFF, 8'h00);
    send_beat(ACT_PIXEL, 8'h00, 8'h00, 8'hFF);
    send_beat(ACT_PIXEL, 8'h00, 8'hFE, 8'h00);
    send_beat(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    play_tail(4);

    // ---- Random phases ----
    phase = 0;
    while (items_played < ITEM_TARGET) begin
      src_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps  = ($urandom_range(0, 3) != 0);
      pick     = $urandom_range(0, 19);
      if (phase == 1) pick = 19;
      if (phase == 2) pick = -1;
      if (phase == 5) pick = 0;

      if (pick == -1) begin
        // Widest frame: 2047 saturates to the line store depth, tallest
        // height. Cut short a little past the first results.
        configure(2047, 65535);
        play_pixels(bb3_pkg::MAX_WIDTH + 1 + $urandom_range(8, 40));
      end else if (pick <= 1) begin
        // Tallest height with a narrow frame, cut short
        configure($urandom_range(1, 3), 65535);
        play_pixels($urandom_range(10, 60));
      end else if (pick <= 4) begin
        // Broken frame: stops anywhere, even inside the tail
        configure($urandom_range(1, 12), $urandom_range(0, 6));
        w = board.eff_width();
        h = board.eff_height();
        play_pixels($urandom_range(0, w * h));
        if (board.row >= h) play_tail($urandom_range(0, w));
      end else begin
        // Whole frames back to back under one setting
        if (phase == 1) begin
          w = 8;
          h = 6;
        end else begin
          w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          h = $urandom_range(0, 8);
        end
        configure(w, h);
        w      = board.eff_width();
        h      = board.eff_height();
        frames = $urandom_range(1, 3);
        // Long receiver hold-off while the sender keeps pushing: the block
        // fills up and must stall its input.
        if (phase == 1 || $urandom_range(0, 7) == 0)
          hold_cycles = (phase == 1) ? 200 : $urandom_range(40, 160);
        repeat (frames) begin
          play_pixels(w * h);
          play_tail(w + 1);
        end
      end
      phase++;
    end

    // ---- Wind-down ----
    wait_results_in();
    n = 0;
    while (n < SETTLE_CYCLES) begin
      @(posedge clk);
      n++;
    end
    board.flush_leftovers();
    if (board.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: several times the slowest correct run
  initial begin
    #5_000_000;
    $display("Timeout: block stopped moving beats");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
